// ===== sv/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; compile before every other file of the block.
package utf8d_pkg;

    typedef logic [20:0] cp_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_STRAY   = 3'd1,
        ST_INTR    = 3'd2,
        ST_INVALID = 3'd3,
        ST_TRUNC   = 3'd4
    } status_t;

    // Sequence lengths; LEN_NONE means no sequence pending
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THR  = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam cp_t CP_MAX     = 21'h10FFFF;
    localparam cp_t SURR_LO    = 21'h00D800;
    localparam cp_t SURR_HI    = 21'h00DFFF;
    localparam cp_t MIN_TWO    = 21'h000080;
    localparam cp_t MIN_THR    = 21'h000800;
    localparam cp_t MIN_FOUR   = 21'h010000;
    localparam cp_t MAX_TWO    = 21'h0007FF;
    localparam cp_t MAX_THR    = 21'h00FFFF;
    localparam cp_t REPL_RESET = 21'h00FFFD;

    // Result queue: depth must be a power of two and at least four
    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = RQ_AW + 1;

    typedef struct packed {
        cp_t         code_point;
        status_t     status;
        logic [2:0]  byte_count;
        logic        text_done;
        logic        last_of_run;
    } result_t;

endpackage

// ===== sv/utf8d_if.sv =====
// Handshake interfaces for the UTF-8 stream decoder: byte items in, code point items out.
// Depends on utf8d_pkg.
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8d_cp_if;
    import utf8d_pkg::*;
    logic       valid;
    logic       ready;
    cp_t        code_point;
    logic [2:0] status;
    logic [2:0] byte_count;
    logic       text_done;
    logic       last_of_run;

    modport source (output valid, output code_point, output status, output byte_count,
                    output text_done, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input status, input byte_count,
                    input text_done, input last_of_run, output ready);
endinterface

// ===== sv/utf8_stream_decoder.sv =====
// UTF-8 stream decoder: one byte item in, zero to two code point items out.
// Depends on utf8d_pkg and the interfaces in utf8d_if.

// An accepted byte is held in an input register, is decoded by fixed mask, shift and
// compare logic against the sequence state, and its results (none, one or two) are written to
// an eight-entry result queue. A byte is taken every cycle while the queue has room, so the
// sustained input rate is one byte per cycle; since the output delivers one result per cycle
// while the sink is ready, a byte that both ends an interrupted sequence and yields a result
// of its own puts two results on the output.
// The replacement code register may be written only while the decoder is idle.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [20:0]   wr_data,
    utf8d_byte_if.sink    text,
    utf8d_cp_if.source    points
);

    cp_t                repl_reg;
    logic [2:0]         exp_reg, exp_next;
    logic [2:0]         rcv_reg, rcv_next;
    cp_t                acc_reg, acc_next;

    logic               stg_vld_reg;
    logic [7:0]         stg_byte_reg;
    logic               stg_eot_reg;

    result_t            rq_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CW-1:0]   cnt_reg, cnt_next;

    result_t            pre_res, main_res;
    logic               pre_vld, main_vld;
    logic               fresh_go, cont, bad;
    cp_t                acc_c, lo, hi;
    logic [2:0]         rcv_c;
    logic [1:0]         n_push;
    logic               pop, accept;

    assign accept = text.valid && text.ready;
    assign pop    = points.valid && points.ready;

    // Room for the staged byte's results plus the next one's
    assign text.ready = ({1'b0, cnt_reg} + (stg_vld_reg ? (RQ_CW+1)'(2) : (RQ_CW+1)'(0)))
                        <= (RQ_CW+1)'(RQ_DEPTH - 2);

    always_comb
    begin
        cont     = (stg_byte_reg[7:6] == 2'b10);
        exp_next = exp_reg;
        rcv_next = rcv_reg;
        acc_next = acc_reg;
        pre_vld  = 1'b0;
        main_vld = 1'b0;
        fresh_go = 1'b0;
        bad      = 1'b0;
        acc_c    = {acc_reg[14:0], stg_byte_reg[5:0]};
        rcv_c    = rcv_reg + 3'd1;
        lo       = (exp_reg == LEN_TWO) ? MIN_TWO : (exp_reg == LEN_THR) ? MIN_THR : MIN_FOUR;
        hi       = (exp_reg == LEN_TWO) ? MAX_TWO : (exp_reg == LEN_THR) ? MAX_THR : CP_MAX;
        pre_res  = '{code_point: repl_reg, status: ST_INTR, byte_count: rcv_reg,
                     text_done: 1'b0, last_of_run: 1'b0};
        main_res = '{code_point: repl_reg, status: ST_TRUNC, byte_count: rcv_c,
                     text_done: 1'b0, last_of_run: 1'b0};

        if (exp_reg != LEN_NONE)
        begin
            if (cont)
            begin
                if (rcv_c >= exp_reg)
                begin
                    // Sequence complete: check overlong, surrogate and range
                    bad = (acc_c < lo) || (acc_c > hi) || ((acc_c >= SURR_LO) && (acc_c <= SURR_HI));
                    main_vld            = 1'b1;
                    main_res.code_point = bad ? repl_reg : acc_c;
                    main_res.status     = bad ? ST_INVALID : ST_OK;
                    main_res.byte_count = exp_reg;
                    exp_next = LEN_NONE;
                    rcv_next = 3'd0;
                    acc_next = '0;
                end
                else if (stg_eot_reg)
                begin
                    main_vld = 1'b1;
                    exp_next = LEN_NONE;
                    rcv_next = 3'd0;
                    acc_next = '0;
                end
                else
                begin
                    rcv_next = rcv_c;
                    acc_next = acc_c;
                end
            end
            else
            begin
                // Cut short: report, then decode this byte afresh
                pre_vld  = 1'b1;
                exp_next = LEN_NONE;
                rcv_next = 3'd0;
                acc_next = '0;
                fresh_go = 1'b1;
            end
        end
        else
        begin
            fresh_go = 1'b1;
        end

        if (fresh_go)
        begin
            main_res.byte_count = LEN_ONE;
            if (!stg_byte_reg[7])
            begin
                main_vld            = 1'b1;
                main_res.code_point = {13'd0, stg_byte_reg};
                main_res.status     = ST_OK;
            end
            else if (cont || (stg_byte_reg[7:3] == 5'b11111))
            begin
                main_vld        = 1'b1;
                main_res.status = ST_STRAY;
            end
            else
            begin
                // Lead byte: open a sequence unless the text ends here
                main_res.status = ST_TRUNC;
                main_vld        = stg_eot_reg;
                if (!stg_eot_reg)
                begin
                    rcv_next = LEN_ONE;
                    if (stg_byte_reg[7:5] == 3'b110)
                    begin
                        exp_next = LEN_TWO;
                        acc_next = {16'd0, stg_byte_reg[4:0]};
                    end
                    else if (stg_byte_reg[7:4] == 4'b1110)
                    begin
                        exp_next = LEN_THR;
                        acc_next = {17'd0, stg_byte_reg[3:0]};
                    end
                    else
                    begin
                        exp_next = LEN_FOUR;
                        acc_next = {18'd0, stg_byte_reg[2:0]};
                    end
                end
            end
        end

        if (main_vld)
        begin
            main_res.text_done   = stg_eot_reg;
            main_res.last_of_run = 1'b1;
        end
        else
        begin
            pre_res.text_done   = stg_eot_reg;
            pre_res.last_of_run = 1'b1;
        end

        n_push   = stg_vld_reg ? ({1'b0, pre_vld} + {1'b0, main_vld}) : 2'd0;
        cnt_next = cnt_reg + RQ_CW'(n_push) - RQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg    <= REPL_RESET;
            exp_reg     <= LEN_NONE;
            rcv_reg     <= 3'd0;
            acc_reg     <= '0;
            stg_vld_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                repl_reg <= wr_data;
            end
            stg_vld_reg <= accept;
            if (stg_vld_reg)
            begin
                exp_reg <= exp_next;
                rcv_reg <= rcv_next;
                acc_reg <= acc_next;
            end
            wr_ptr_reg <= wr_ptr_reg + RQ_AW'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload: input register and queue entries
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_byte_reg <= text.data_byte;
            stg_eot_reg  <= text.end_of_text;
        end
        if (stg_vld_reg)
        begin
            if (pre_vld)
            begin
                rq_reg[wr_ptr_reg] <= pre_res;
                if (main_vld)
                begin
                    rq_reg[wr_ptr_reg + RQ_AW'(1)] <= main_res;
                end
            end
            else if (main_vld)
            begin
                rq_reg[wr_ptr_reg] <= main_res;
            end
        end
    end

    assign points.valid       = (cnt_reg != '0);
    assign points.code_point  = rq_reg[rd_ptr_reg].code_point;
    assign points.status      = rq_reg[rd_ptr_reg].status;
    assign points.byte_count  = rq_reg[rd_ptr_reg].byte_count;
    assign points.text_done   = rq_reg[rd_ptr_reg].text_done;
    assign points.last_of_run = rq_reg[rd_ptr_reg].last_of_run;

endmodule

// ===== sv/utf8d_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on utf8d_pkg and utf8_stream_decoder.
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input cp_t         code_point,
    input logic [2:0]  status,
    input logic [2:0]  byte_count,
    input logic        text_done,
    input logic        last_of_run
);

    // Hold a stalled item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(status))
        else $error("stalled item changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> last_of_run)
        else $error("text_done without last_of_run");

    // A good item carries a scalar value and a nonzero byte count
    a_ok_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> (code_point <= CP_MAX)
            && !((code_point >= SURR_LO) && (code_point <= SURR_HI))
            && (byte_count != LEN_NONE))
        else $error("bad value reported as good");

    a_stray_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_STRAY) |-> (byte_count == LEN_ONE))
        else $error("stray byte item with wrong count");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (points.valid),
    .out_ready   (points.ready),
    .code_point  (points.code_point),
    .status      (points.status),
    .byte_count  (points.byte_count),
    .text_done   (points.text_done),
    .last_of_run (points.last_of_run)
);
